FILE: rtl/keyed_fifo_unique_keys_top_defines.svh
// Assertion macros for the keyed FIFO RTL, included by kfuk_datapath.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef KEYED_FIFO_UNIQUE_KEYS_TOP_DEFINES_SVH
`define KEYED_FIFO_UNIQUE_KEYS_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define KFUK_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define KFUK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kfuk_pkg.sv
package kfuk_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned DataW         = 32;
  localparam int unsigned TypeW         = 2;
  localparam int unsigned StatusW       = 3;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_UPD
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_UPDATED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEQ_RD,
    S_COMMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic commit;
    op_e  op;
  } kfuk_cmd_t;

  typedef struct packed {
    logic scan_done;
  } kfuk_stat_t;

  // Only the upper bit selects an update, so the unused type code acts as one.
  function automatic op_e decode_op(input logic [TypeW-1:0] req_type);
    op_e op;
    if (req_type[1]) begin
      op = OP_UPD;
    end else if (req_type[0]) begin
      op = OP_DEQ;
    end else begin
      op = OP_ENQ;
    end
    return op;
  endfunction

endpackage

FILE: rtl/kfuk_ctrl.sv
module kfuk_ctrl
  import kfuk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TypeW-1:0] in_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kfuk_cmd_t        cmd_o,
  input  kfuk_stat_t       stat_i
);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  op_e    in_op;

  assign in_op = decode_op(in_type_i);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op;
          state_d = (in_op == OP_DEQ) ? S_DEQ_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_DEQ_RD: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.scan_init = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.op        = op_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i;
        cmd_o.scan_init = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_DEQ_RD: begin
        cmd_o.op = op_q;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ENQ;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: rtl/kfuk_datapath.sv
`include "keyed_fifo_unique_keys_top_defines.svh"

module kfuk_datapath
  import kfuk_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kfuk_cmd_t               cmd_i,
  output kfuk_stat_t              stat_o,
  input  logic signed [KeyW-1:0]  req_key_i,
  input  logic signed [DataW-1:0] req_data_i,
  output status_e                 status_o,
  output logic signed [KeyW-1:0]  out_key_o,
  output logic signed [DataW-1:0] out_data_o,
  output logic                    not_found_o,
  output logic [CntW-1:0]         occupancy_o,
  output logic                    is_empty_o
);

  localparam int unsigned IdxW    = $clog2(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  logic [KeyW-1:0]  key_mem [QUEUE_DEPTH];
  logic [DataW-1:0] data_mem [QUEUE_DEPTH];

  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  rd_ptr_q, slot_q, found_slot_q;
  logic [CntW-1:0]  left_q;
  logic             pend_q, found_q;
  logic [KeyW-1:0]  key_q, key_rd_q;
  logic [DataW-1:0] data_q, data_rd_q;

  status_e          status_q, status_d;
  logic [KeyW-1:0]  okey_q, okey_d;
  logic [DataW-1:0] odata_q, odata_d;
  logic             nf_q, nf_d;
  logic [CntW-1:0]  occ_q;
  logic             empty_q;

  logic             issue;
  logic [IdxW-1:0]  rd_addr;
  logic             key_we, data_we;
  logic [IdxW-1:0]  data_waddr;
  logic             is_full;

  assign is_full = (cnt_q == FullCnt);
  assign issue   = cmd_i.scan_step && (left_q != '0) && !found_q;
  assign rd_addr = (cmd_i.op == OP_DEQ) ? head_q : rd_ptr_q;

  assign stat_o.scan_done = found_q || ((left_q == '0) && !pend_q);

  assign key_we     = cmd_i.commit && (cmd_i.op == OP_ENQ) && !found_q && !is_full;
  assign data_we    = key_we || (cmd_i.commit && (cmd_i.op == OP_UPD) && found_q);
  assign data_waddr = (cmd_i.op == OP_UPD) ? found_slot_q : tail_q;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[tail_q] <= key_q;
    end
    if (data_we) begin
      data_mem[data_waddr] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[rd_addr];
    data_rd_q <= data_mem[head_q];
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    status_d = ST_UPDATED;
    okey_d   = '0;
    odata_d  = '0;
    nf_d     = 1'b0;
    case (cmd_i.op)
      OP_ENQ: begin
        if (found_q) begin
          status_d = ST_DUPLICATE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ENQUEUED;
          tail_d   = next_idx(tail_q);
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      OP_DEQ: begin
        if (cnt_q == '0) begin
          status_d = ST_UNDERFLOW;
        end else begin
          status_d = ST_DEQUEUED;
          okey_d   = key_rd_q;
          odata_d  = data_rd_q;
          head_d   = next_idx(head_q);
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      OP_UPD: begin
        status_d = ST_UPDATED;
        nf_d     = !found_q;
      end
      default: begin
        status_d = ST_UPDATED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      rd_ptr_q <= '0;
      left_q   <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (cmd_i.scan_init) begin
        rd_ptr_q <= head_q;
        left_q   <= cnt_q;
        pend_q   <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_q <= issue;
        if (issue) begin
          rd_ptr_q <= next_idx(rd_ptr_q);
          left_q   <= left_q - CntW'(1);
        end
        if (pend_q && !found_q && (key_rd_q == key_q)) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= req_key_i;
      data_q <= req_data_i;
    end
    if (issue) begin
      slot_q <= rd_ptr_q;
    end
    if (cmd_i.scan_step && pend_q && !found_q && (key_rd_q == key_q)) begin
      found_slot_q <= slot_q;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      odata_q  <= odata_d;
      nf_q     <= nf_d;
      occ_q    <= cnt_d;
      empty_q  <= (cnt_d == '0);
    end
  end

  assign status_o    = status_q;
  assign out_key_o   = okey_q;
  assign out_data_o  = odata_q;
  assign not_found_o = nf_q;
  assign occupancy_o = occ_q;
  assign is_empty_o  = empty_q;

  `KFUK_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= FullCnt, "entry count exceeds queue depth")
  `KFUK_ASSERT_NEXT(a_cnt_only_commit, !cmd_i.commit, $stable(cnt_q), "count moved without commit")
  `KFUK_ASSERT_NEXT(a_found_sticky, cmd_i.scan_step && found_q, found_q, "match lost during scan")
  `KFUK_ASSERT_NEXT(a_enq_grows, key_we, cnt_q == CntW'($past(cnt_q) + CntW'(1)), "enqueue count")
  `KFUK_ASSERT_NEXT(a_underflow, cmd_i.commit && (cmd_i.op == OP_DEQ) && (cnt_q == '0), status_q == ST_UNDERFLOW && okey_q == '0, "underflow result")

endmodule

FILE: rtl/keyed_fifo_unique_keys_top.sv
// Keyed FIFO with unique keys.
// The request channel carries one beat per request: tuser holds the request
// type (enqueue, dequeue, or update by key) and tdata holds the key and data.
// The result channel returns exactly one beat per request with a status code
// in tuser and, in tdata, the dequeued key and data, a not-found flag, the
// occupancy after the request and an empty flag.
// Enqueue and update search the held keys from oldest to newest, one key per
// cycle through the key memory read port, and stop early when the key is
// found; the request is then committed and its result beat returned.
// Dequeue skips the search: it reads the head entry, commits and responds.
// One request is processed at a time, and a new request beat is accepted in
// the cycle after the previous result beat has been taken.
// Reset empties the queue; the memories are not cleared, since entries are
// only read once written.
// While the receiver holds tready low the result beat stays valid and stable
// and no new request is accepted.
module keyed_fifo_unique_keys_top
  import kfuk_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  localparam int unsigned CntW       = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OutBits    = KeyW + DataW + 2 + CntW,
  localparam int unsigned TdataW     = ((OutBits + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // req_key, req_data
  input  logic [KeyW+DataW-1:0]    s_axis_tdata_i,
  // req_type
  input  logic [TypeW-1:0]         s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // out_key, out_data, not_found, occupancy, is_empty, zero padding
  output logic [TdataW-1:0]        m_axis_tdata_o,
  // status
  output logic [StatusW-1:0]       m_axis_tuser_o
);

  kfuk_cmd_t               cmd;
  kfuk_stat_t              stat;
  status_e                 status;
  logic signed [KeyW-1:0]  out_key;
  logic signed [DataW-1:0] out_data;
  logic                    not_found;
  logic [CntW-1:0]         occupancy;
  logic                    is_empty;

  kfuk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_type_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  kfuk_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_key_i   (s_axis_tdata_i[KeyW-1:0]),
    .req_data_i  (s_axis_tdata_i[KeyW+DataW-1:KeyW]),
    .status_o    (status),
    .out_key_o   (out_key),
    .out_data_o  (out_data),
    .not_found_o (not_found),
    .occupancy_o (occupancy),
    .is_empty_o  (is_empty)
  );

  assign m_axis_tdata_o = TdataW'({is_empty, occupancy, not_found, out_data, out_key});
  assign m_axis_tuser_o = status;

endmodule
